[src/mlp_pkg.sv]
package mlp_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int STEP_W       = 16;
  localparam int WEIGHT_W     = 32;
  localparam int MLP_CHANNELS = 4;
  localparam int MLP_ORDER    = 4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ERR,
    ST_UPD,
    ST_SHIFT,
    ST_PRED,
    ST_OUT
  } state_t;

endpackage

[src/multichannel_lms_predictor_top.sv]
// multichannel lms one-step predictor
// in_*  : one item is a vector of CHANNELS signed q1.15 samples, channel 0 lowest
// out_* : one item per input item, the predicted next vector, q1.15 saturated
// cfg_* : step size (unsigned q0.16), written by the user only while the block is
// idle, which the block does not enforce; the block takes one item at a time;
// in_tready is high only when idle; one shared 34x17 multiplier does all the work
// under a small sequencer: the scaled errors channel by channel, the weight update
// pass, the history shift, the prediction pass and the load of the output register;
// the two passes go through the shared multiplier one weight a cycle; the result
// is in the output register in the same cycle that in_tready is high again, so no
// new item is taken before the result of the last is in the output register
// after reset the weight memory is cleared one entry a cycle, and all
// CHANNELS*CHANNELS*ORDER entries are cleared before the first item is accepted
// a finished result waits in the output register; if the receiver stalls the
// next item is still taken and worked on, and only its result waits for the
// output register to empty, with in_tready low until it does
module multichannel_lms_predictor_top
  import mlp_pkg::*;
#(
  parameter int CHANNELS = MLP_CHANNELS,
  parameter int ORDER    = MLP_ORDER
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [CHANNELS*SAMPLE_W-1:0] in_tdata,   // sample_0 .. sample_n, low bits up
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [CHANNELS*SAMPLE_W-1:0] out_tdata,  // predict_0 .. predict_n, low bits up
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [STEP_W-1:0]            cfg_data    // step_size
);

  localparam int HIST_LEN = CHANNELS * ORDER;
  localparam int NUM_W    = CHANNELS * HIST_LEN;
  localparam int AW       = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int JW       = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
  localparam int CNT_W    = $clog2(NUM_W + 3);
  localparam int ACC_W    = 52 + JW;
  localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(1) << 26;
  localparam logic signed [50:0]      INC_BIAS = 51'(1) << 18;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r;
  logic [CW-1:0]    c_r;
  logic [JW-1:0]    j_r;

  logic [STEP_W-1:0]          step_r;
  logic signed [SAMPLE_W-1:0] x_r    [CHANNELS];
  logic signed [SAMPLE_W-1:0] pred_r [CHANNELS];
  logic signed [33:0]         err_r  [CHANNELS];
  logic signed [SAMPLE_W-1:0] hist_r [HIST_LEN];

  logic signed [WEIGHT_W-1:0] wmem [NUM_W];
  logic signed [WEIGHT_W-1:0] rd_data_r;

  logic                       v_s1_r, v_s2_r, v_s3_r;
  logic [CW-1:0]              c_s1_r, c_s2_r, c_s3_r;
  logic                       first_s1_r, first_s2_r;
  logic                       last_s1_r, last_s2_r, last_s3_r;
  logic [AW-1:0]              addr_s1_r, addr_s2_r, addr_s3_r;
  logic signed [SAMPLE_W-1:0] h_s1_r;
  logic signed [WEIGHT_W-1:0] w_s2_r, w_s3_r;
  logic signed [50:0]         prod_r;
  logic signed [31:0]         inc_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic                         out_valid_r;
  logic [CHANNELS*SAMPLE_W-1:0] out_data_r;

  logic                   issue;
  logic                   pass_end;
  logic                   load_out;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          rd_addr;
  logic signed [WEIGHT_W-1:0] mem_wdata;
  logic [CW-1:0]          ins_sel;
  logic signed [16:0]     diff;
  logic signed [33:0]     mul_a;
  logic signed [16:0]     mul_b;
  logic signed [50:0]     mul_p;
  logic signed [50:0]     rnd;
  logic signed [32:0]     wsum;
  logic signed [WEIGHT_W-1:0] wsat;
  logic signed [ACC_W-1:0]    acc_base;
  logic                   pos_ovf, neg_ovf;
  logic signed [SAMPLE_W-1:0] psat;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == CNT_W'(NUM_W - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_ERR;
      end
      ST_ERR: begin
        if (c_r == CW'(CHANNELS - 1)) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (pass_end) state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (c_r == CW'(CHANNELS - 1)) state_nxt = ST_PRED;
      end
      ST_PRED: begin
        if (pass_end) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    load_out  = 1'b0;
    mem_we    = 1'b0;
    case (state_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE:  in_tready = 1'b1;
      ST_UPD: begin
        issue  = (cnt_r < CNT_W'(NUM_W));
        mem_we = v_s3_r;
      end
      ST_PRED:  issue = (cnt_r < CNT_W'(NUM_W));
      ST_OUT:   load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign pass_end  = (cnt_r == CNT_W'(NUM_W + 2));
  assign rd_addr   = cnt_r[AW-1:0];
  assign mem_waddr = (state_r == ST_CLEAR) ? cnt_r[AW-1:0] : addr_s3_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : wsat;
  assign ins_sel   = CW'(CHANNELS - 1) - c_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      c_r   <= '0;
      j_r   <= '0;
    end else if (state_r != state_nxt) begin
      cnt_r <= '0;
      c_r   <= '0;
      j_r   <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: cnt_r <= cnt_r + CNT_W'(1);
        ST_ERR, ST_SHIFT: c_r <= c_r + CW'(1);
        ST_UPD, ST_PRED: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (issue) begin
            if (j_r == JW'(HIST_LEN - 1)) begin
              j_r <= '0;
              c_r <= c_r + CW'(1);
            end else begin
              j_r <= j_r + JW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cfg_valid) begin
      step_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      for (int c = 0; c < CHANNELS; c++) begin
        x_r[c] <= in_tdata[c*SAMPLE_W +: SAMPLE_W];
      end
    end
  end

  // shared multiplier
  assign diff = {x_r[c_r][SAMPLE_W-1], x_r[c_r]} - {pred_r[c_r][SAMPLE_W-1], pred_r[c_r]};

  always_comb begin
    case (state_r)
      ST_ERR: begin
        mul_a = 34'(diff);
        mul_b = {1'b0, step_r};
      end
      ST_UPD: begin
        mul_a = err_r[c_s1_r];
        mul_b = 17'(h_s1_r);
      end
      default: begin
        mul_a = 34'(rd_data_r);
        mul_b = 17'(h_s1_r);
      end
    endcase
  end

  assign mul_p = 51'(mul_a) * 51'(mul_b);

  always_ff @(posedge clk) begin
    if (state_r == ST_ERR) begin
      err_r[c_r] <= mul_p[33:0];
    end
  end

  // history ring, head at entry 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_r[i] <= '0;
      end
    end else if (state_r == ST_SHIFT) begin
      hist_r[0] <= x_r[ins_sel];
      for (int i = 1; i < HIST_LEN; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end else if (issue) begin
      for (int i = 0; i < HIST_LEN - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[HIST_LEN-1] <= hist_r[0];
    end
  end

  // weight memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wmem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data_r <= wmem[rd_addr];
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0;
      v_s2_r <= 1'b0;
      v_s3_r <= 1'b0;
    end else begin
      v_s1_r <= issue;
      v_s2_r <= v_s1_r;
      v_s3_r <= v_s2_r;
    end
  end

  assign rnd      = prod_r + INC_BIAS;
  assign acc_base = first_s2_r ? ACC_BIAS : acc_r;

  always_ff @(posedge clk) begin
    c_s1_r     <= c_r;
    first_s1_r <= (j_r == '0);
    last_s1_r  <= (j_r == JW'(HIST_LEN - 1));
    addr_s1_r  <= rd_addr;
    h_s1_r     <= hist_r[0];

    c_s2_r     <= c_s1_r;
    first_s2_r <= first_s1_r;
    last_s2_r  <= last_s1_r;
    addr_s2_r  <= addr_s1_r;
    w_s2_r     <= rd_data_r;
    prod_r     <= mul_p;

    c_s3_r     <= c_s2_r;
    last_s3_r  <= last_s2_r;
    addr_s3_r  <= addr_s2_r;
    w_s3_r     <= w_s2_r;
    inc_r      <= rnd[50:19];
    if (v_s2_r && state_r == ST_PRED) begin
      acc_r <= acc_base + {{(ACC_W-51){prod_r[50]}}, prod_r};
    end
  end

  // weight saturation
  assign wsum = {w_s3_r[WEIGHT_W-1], w_s3_r} + {inc_r[31], inc_r};

  always_comb begin
    if (wsum[32] != wsum[31]) begin
      wsat = wsum[32] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else begin
      wsat = wsum[31:0];
    end
  end

  // prediction rounding and saturation
  assign pos_ovf = !acc_r[ACC_W-1] && (|acc_r[ACC_W-1:42]);
  assign neg_ovf = acc_r[ACC_W-1] && !(&acc_r[ACC_W-1:42]);

  always_comb begin
    if (pos_ovf) begin
      psat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (neg_ovf) begin
      psat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      psat = acc_r[42:27];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pred_r[c] <= '0;
      end
    end else if (state_r == ST_PRED && v_s3_r && last_s3_r) begin
      pred_r[c_s3_r] <= psat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_data_r[c*SAMPLE_W +: SAMPLE_W] <= pred_r[c];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
